[design/tpd_pkg.sv]
// ----------------------------------------------------------------------------
// tpd_pkg: shared types and constants of the touch packet decoder
// Character codes, register indexes, fixed-point constants and the structs
// passed between the front end, the queue and the back end.
// ----------------------------------------------------------------------------
package tpd_pkg;

   // characters
   localparam logic [7:0] CH_T     = 8'h54;
   localparam logic [7:0] CH_R     = 8'h52;
   localparam logic [7:0] CH_CR    = 8'h0d;
   localparam logic [7:0] CH_TAB   = 8'h09;
   localparam logic [7:0] CH_SPACE = 8'h20;
   localparam logic [7:0] CH_PLUS  = 8'h2b;
   localparam logic [7:0] CH_MINUS = 8'h2d;
   localparam logic [7:0] CH_ZERO  = 8'h30;
   localparam logic [7:0] CH_NINE  = 8'h39;

   // packet layout
   localparam logic [3:0] POS_X_FIRST = 4'd1;
   localparam logic [3:0] POS_X_LAST  = 4'd4;
   localparam logic [3:0] POS_Y_FIRST = 4'd6;
   localparam logic [3:0] POS_Y_LAST  = 4'd9;
   localparam logic [3:0] POS_END     = 4'd10;  // last byte of 11

   localparam logic [13:0] RAW_MAX = 14'd1023;

   // register indexes
   localparam logic [2:0] REG_CAL_X_LOW     = 3'd0;
   localparam logic [2:0] REG_CAL_Y_LOW     = 3'd1;
   localparam logic [2:0] REG_CAL_X_HIGH    = 3'd2;
   localparam logic [2:0] REG_CAL_Y_HIGH    = 3'd3;
   localparam logic [2:0] REG_DISP_WIDTH    = 3'd4;
   localparam logic [2:0] REG_DISP_HEIGHT   = 3'd5;
   localparam logic [2:0] REG_SMOOTH_WEIGHT = 3'd6;

   // divider geometry
   localparam int DIV_N_W = 42;
   localparam int DIV_D_W = 18;

   typedef struct packed {
      logic [9:0]  cal_x_low;
      logic [9:0]  cal_y_low;
      logic [9:0]  cal_x_high;
      logic [9:0]  cal_y_high;
      logic [12:0] disp_width;
      logic [12:0] disp_height;
      logic [7:0]  smooth_weight;
   } cfg_type;

   // decoded packet handed to the back end
   typedef struct packed {
      logic       touch;
      logic [9:0] raw_x;
      logic [9:0] raw_y;
   } qitem_type;

endpackage

[design/tpd_front.sv]
// ----------------------------------------------------------------------------
// tpd_front: byte collector and field parser
// Tracks the byte position, parses both decimal fields on the fly and pushes
// a decoded packet into the queue when the last byte arrives and both fields are in range.
// ----------------------------------------------------------------------------
module tpd_front (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_tvalid,
   output logic                req_tready,
   input  logic [7:0]          req_tdata,   // [7:0] rx_byte
   input  logic                q_full,
   output logic                q_push,
   output tpd_pkg::qitem_type  q_item
);
   import tpd_pkg::*;

   typedef enum logic [2:0] {
      PM_SPACE = 3'b001,
      PM_DIGIT = 3'b010,
      PM_DONE  = 3'b100
   } pmode_type;

   typedef struct packed {
      pmode_type   mode;
      logic        neg;
      logic [13:0] val;
   } field_type;

   localparam field_type FIELD_INIT = '{mode: PM_SPACE, neg: 1'b0, val: 14'd0};

   function automatic field_type field_step(field_type f, logic [7:0] b);
      field_type r;
      logic      is_dig;
      logic      is_sp;
      logic [17:0] acc;
      r      = f;
      is_dig = (b >= CH_ZERO) && (b <= CH_NINE);
      is_sp  = (b == CH_SPACE) || ((b >= CH_TAB) && (b <= CH_CR));
      acc    = 18'(f.val) * 18'd10 + 18'(b - CH_ZERO);
      case (f.mode)
         PM_SPACE: begin
            if (is_sp) begin
               r.mode = PM_SPACE;
            end else if (b == CH_PLUS || b == CH_MINUS) begin
               r.neg  = (b == CH_MINUS);
               r.mode = PM_DIGIT;
            end else if (is_dig) begin
               r.val  = acc[13:0];
               r.mode = PM_DIGIT;
            end else begin
               r.mode = PM_DONE;
            end
         end
         PM_DIGIT: begin
            if (is_dig) begin
               r.val = acc[13:0];
            end else begin
               r.mode = PM_DONE;
            end
         end
         default: r.mode = PM_DONE;
      endcase
      return r;
   endfunction

   function automatic logic field_ok(field_type f);
      return !(f.neg && (f.val != 14'd0)) && (f.val <= RAW_MAX);
   endfunction

   logic [3:0] cnt_ff, cnt_in;
   field_type  fx_ff, fx_in, fy_ff, fy_in;
   logic       touch_ff, touch_in;
   logic       take;

   assign req_tready = !((cnt_ff == POS_END) && q_full);
   assign take       = req_tvalid && req_tready;

   // byte position and parsing
   always_comb begin
      cnt_in   = cnt_ff;
      fx_in    = fx_ff;
      fy_in    = fy_ff;
      touch_in = touch_ff;
      q_push   = 1'b0;
      if (take) begin
         if (cnt_ff == 4'd0) begin
            if (req_tdata == CH_T || req_tdata == CH_R) begin
               touch_in = (req_tdata == CH_T);
               cnt_in   = 4'd1;
               fx_in    = FIELD_INIT;
               fy_in    = FIELD_INIT;
            end
         end else if (req_tdata == CH_CR && cnt_ff != POS_END) begin
            cnt_in = 4'd0;
         end else if (cnt_ff == POS_END) begin
            cnt_in = 4'd0;
            q_push = field_ok(fx_ff) && field_ok(fy_ff);
         end else begin
            cnt_in = cnt_ff + 4'd1;
            if (cnt_ff >= POS_X_FIRST && cnt_ff <= POS_X_LAST) begin
               fx_in = field_step(fx_ff, req_tdata);
            end
            if (cnt_ff >= POS_Y_FIRST && cnt_ff <= POS_Y_LAST) begin
               fy_in = field_step(fy_ff, req_tdata);
            end
         end
      end
   end

   assign q_item = '{touch: touch_ff, raw_x: fx_ff.val[9:0], raw_y: fy_ff.val[9:0]};

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= 4'd0;
      end else begin
         cnt_ff <= cnt_in;
      end
      fx_ff    <= fx_in;
      fy_ff    <= fy_in;
      touch_ff <= touch_in;
   end

endmodule

[design/tpd_queue.sv]
// ----------------------------------------------------------------------------
// tpd_queue: two-entry packet queue
// Decouples the byte parser from the arithmetic back end.
// ----------------------------------------------------------------------------
module tpd_queue (
   input  logic                clock,
   input  logic                reset,
   input  logic                push,
   input  tpd_pkg::qitem_type  push_item,
   output logic                full,
   input  logic                pop,
   output logic                not_empty,
   output tpd_pkg::qitem_type  pop_item
);
   import tpd_pkg::*;

   qitem_type  mem_ff [2];
   logic       wp_ff, wp_in, rp_ff, rp_in;
   logic [1:0] cnt_ff, cnt_in;

   assign full      = (cnt_ff == 2'd2);
   assign not_empty = (cnt_ff != 2'd0);
   assign pop_item  = mem_ff[rp_ff];

   // pointer and fill update
   always_comb begin
      wp_in  = push ? !wp_ff : wp_ff;
      rp_in  = pop ? !rp_ff : rp_ff;
      cnt_in = cnt_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff  <= 1'b0;
         rp_ff  <= 1'b0;
         cnt_ff <= 2'd0;
      end else begin
         wp_ff  <= wp_in;
         rp_ff  <= rp_in;
         cnt_ff <= cnt_in;
      end
      if (push) begin
         mem_ff[wp_ff] <= push_item;
      end
   end

endmodule

[design/tpd_divider.sv]
// ----------------------------------------------------------------------------
// tpd_divider: shared signed radix-2 divider
// Truncating signed division, one quotient bit per cycle, 42 steps.
// ----------------------------------------------------------------------------
module tpd_divider (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   input  logic signed [tpd_pkg::DIV_N_W-1:0]  dividend,
   input  logic signed [tpd_pkg::DIV_D_W-1:0]  divisor,
   output logic                                done,
   output logic signed [tpd_pkg::DIV_N_W-1:0]  quotient
);
   import tpd_pkg::*;

   logic                   busy_ff, busy_in, done_ff, done_in, neg_ff, neg_in;
   logic [5:0]             cnt_ff, cnt_in;
   logic [DIV_D_W-1:0]     rem_ff, rem_in, dmag_ff, dmag_in;
   logic [DIV_N_W-1:0]     quo_ff, quo_in, res_ff, res_in;
   logic [DIV_D_W:0]       rem_sh;
   logic                   ge;

   // restoring step
   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      neg_in  = neg_ff;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      dmag_in = dmag_ff;
      quo_in  = quo_ff;
      res_in  = res_ff;
      rem_sh  = {rem_ff, quo_ff[DIV_N_W-1]};
      ge      = rem_sh >= {1'b0, dmag_ff};
      if (start && !busy_ff) begin
         busy_in = 1'b1;
         cnt_in  = 6'(DIV_N_W - 1);
         rem_in  = '0;
         quo_in  = dividend[DIV_N_W-1] ? DIV_N_W'(-dividend) : DIV_N_W'(dividend);
         dmag_in = divisor[DIV_D_W-1] ? DIV_D_W'(-divisor) : DIV_D_W'(divisor);
         neg_in  = dividend[DIV_N_W-1] ^ divisor[DIV_D_W-1];
      end else if (busy_ff) begin
         rem_in = ge ? DIV_D_W'(rem_sh - {1'b0, dmag_ff}) : rem_sh[DIV_D_W-1:0];
         quo_in = {quo_ff[DIV_N_W-2:0], ge};
         cnt_in = cnt_ff - 6'd1;
         if (cnt_ff == 6'd0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
            res_in  = neg_ff ? DIV_N_W'(-quo_in) : quo_in;
         end
      end
   end

   assign done     = done_ff;
   assign quotient = signed'(res_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      neg_ff  <= neg_in;
      cnt_ff  <= cnt_in;
      rem_ff  <= rem_in;
      dmag_ff <= dmag_in;
      quo_ff  <= quo_in;
      res_ff  <= res_in;
   end

endmodule

[design/tpd_back.sv]
// ----------------------------------------------------------------------------
// tpd_back: calibration, smoothing and screen scaling
// Sequencer over both axes that shares one divider, then the change test
// and the result register.
// ----------------------------------------------------------------------------
module tpd_back (
   input  logic                clock,
   input  logic                reset,
   input  tpd_pkg::cfg_type    cfg,
   input  logic                q_valid,
   input  tpd_pkg::qitem_type  q_item,
   output logic                q_pop,
   output logic                rsp_tvalid,
   input  logic                rsp_tready,
   output logic [31:0]         rsp_tdata   // [12:0] pos_x, [25:13] pos_y, [26] moved,
                                           // [27] touch_changed, [28] touched
);
   import tpd_pkg::*;

   typedef enum logic [9:0] {
      ST_IDLE     = 10'b0000000001,
      ST_CAL_MUL  = 10'b0000000010,
      ST_CAL_GO   = 10'b0000000100,
      ST_CAL_WAIT = 10'b0000001000,
      ST_BLD_MUL  = 10'b0000010000,
      ST_BLD_GO   = 10'b0000100000,
      ST_BLD_WAIT = 10'b0001000000,
      ST_SCR_MUL  = 10'b0010000000,
      ST_SCR_DIV  = 10'b0100000000,
      ST_FIN      = 10'b1000000000
   } state_type;

   state_type                  state_ff, state_in;
   qitem_type                  item_ff, item_in;
   logic                       axis_ff, axis_in, zero_ff, zero_in;
   logic signed [27:0]         v_ff, v_in;
   logic signed [DIV_N_W-1:0]  opn_ff, opn_in;
   logic signed [DIV_D_W-1:0]  opd_ff, opd_in;
   logic [28:0]                prod_ff, prod_in;
   logic [12:0]                rx_ff, rx_in, ry_ff, ry_in;
   logic [12:0]                last_x_ff, last_x_in, last_y_ff, last_y_in;
   logic                       last_touch_ff, last_touch_in, rel_ff, rel_in;
   logic                       rsp_valid_ff, rsp_valid_in;
   logic [31:0]                rsp_data_ff, rsp_data_in;

   logic                       div_start, div_done;
   logic signed [DIV_N_W-1:0]  div_q;

   logic [9:0]                 raw, lo, hi;
   logic signed [10:0]         diff, span;
   logic [12:0]                size, last;
   logic [20:0]                lw;
   logic signed [27:0]         cal;
   logic [15:0]                scl_op;
   logic [28:0]                scr_sum;
   logic [12:0]                clamp;
   logic                       moved, tchg;

   tpd_divider u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (opn_ff),
      .divisor  (opd_ff),
      .done     (div_done),
      .quotient (div_q)
   );

   assign div_start = (state_ff == ST_CAL_GO) || (state_ff == ST_BLD_GO);

   // per-axis operand selection
   always_comb begin
      raw   = axis_ff ? item_ff.raw_y : item_ff.raw_x;
      lo    = axis_ff ? cfg.cal_y_low : cfg.cal_x_low;
      hi    = axis_ff ? cfg.cal_y_high : cfg.cal_x_high;
      size  = axis_ff ? cfg.disp_height : cfg.disp_width;
      last  = axis_ff ? last_y_ff : last_x_ff;
      diff  = signed'({1'b0, raw}) - signed'({1'b0, lo});
      span  = signed'({1'b0, hi}) - signed'({1'b0, lo});
      lw    = 21'(last) * 21'(cfg.smooth_weight);
      cal   = 28'sd8192 + (zero_ff ? 28'sd0 : div_q[27:0]);
      // scaling operand: negative lands on 0, 65535 and above on full size
      if (v_ff[27]) begin
         scl_op = 16'd0;
      end else if (v_ff >= 28'sd65535) begin
         scl_op = 16'hffff;
      end else begin
         scl_op = v_ff[15:0];
      end
      // floor(p / 65535) for p below 2^29: (p + (p >> 16) + 1) >> 16
      scr_sum = prod_ff + 29'(prod_ff[28:16]) + 29'd1;
      clamp   = scr_sum[28:16];
      moved = (rx_ff != last_x_ff) || (ry_ff != last_y_ff);
      tchg  = item_ff.touch != last_touch_ff;
   end

   // sequencer
   always_comb begin
      state_in      = state_ff;
      item_in       = item_ff;
      axis_in       = axis_ff;
      zero_in       = zero_ff;
      v_in          = v_ff;
      opn_in        = opn_ff;
      opd_in        = opd_ff;
      prod_in       = prod_ff;
      rx_in         = rx_ff;
      ry_in         = ry_ff;
      last_x_in     = last_x_ff;
      last_y_in     = last_y_ff;
      last_touch_in = last_touch_ff;
      rel_in        = rel_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      rsp_data_in   = rsp_data_ff;
      q_pop         = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (q_valid) begin
               q_pop    = 1'b1;
               item_in  = q_item;
               axis_in  = 1'b0;
               state_in = ST_CAL_MUL;
            end
         end
         ST_CAL_MUL: begin
            opn_in   = DIV_N_W'(diff) * 42'sd49152;
            opd_in   = DIV_D_W'(span);
            zero_in  = (span == 11'sd0);
            state_in = ST_CAL_GO;
         end
         ST_CAL_GO: state_in = ST_CAL_WAIT;
         ST_CAL_WAIT: begin
            if (div_done) begin
               v_in     = axis_ff ? (28'sd65535 - cal) : cal;
               state_in = rel_ff ? ST_SCR_MUL : ST_BLD_MUL;
            end
         end
         ST_BLD_MUL: begin
            opn_in   = DIV_N_W'(signed'(28'(lw)) + v_ff);
            opd_in   = DIV_D_W'({1'b0, cfg.smooth_weight} + 9'd1);
            state_in = ST_BLD_GO;
         end
         ST_BLD_GO: state_in = ST_BLD_WAIT;
         ST_BLD_WAIT: begin
            if (div_done) begin
               v_in     = div_q[27:0];
               state_in = ST_SCR_MUL;
            end
         end
         ST_SCR_MUL: begin
            prod_in  = 29'(scl_op) * 29'(size);
            state_in = ST_SCR_DIV;
         end
         ST_SCR_DIV: begin
            if (axis_ff) begin
               ry_in    = clamp;
               state_in = ST_FIN;
            end else begin
               rx_in    = clamp;
               axis_in  = 1'b1;
               state_in = ST_CAL_MUL;
            end
         end
         ST_FIN: begin
            if (!rsp_valid_ff || rsp_tready) begin
               last_x_in     = rx_ff;
               last_y_in     = ry_ff;
               last_touch_in = item_ff.touch;
               rel_in        = !item_ff.touch;
               if (moved || tchg) begin
                  rsp_valid_in = 1'b1;
                  rsp_data_in  = {3'b000, item_ff.touch, tchg, moved, ry_ff, rx_ff};
               end
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         last_x_ff     <= 13'd0;
         last_y_ff     <= 13'd0;
         last_touch_ff <= 1'b0;
         rel_ff        <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         last_x_ff     <= last_x_in;
         last_y_ff     <= last_y_in;
         last_touch_ff <= last_touch_in;
         rel_ff        <= rel_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
      item_ff     <= item_in;
      axis_ff     <= axis_in;
      zero_ff     <= zero_in;
      v_ff        <= v_in;
      opn_ff      <= opn_in;
      opd_ff      <= opd_in;
      prod_ff     <= prod_in;
      rx_ff       <= rx_in;
      ry_ff       <= ry_in;
      rsp_data_ff <= rsp_data_in;
   end

endmodule

[design/touch_packet_decoder_core.sv]
// ----------------------------------------------------------------------------
// touch_packet_decoder_core: serial touch panel packet decoder
// Collects ASCII touch packets byte by byte and reports calibrated,
// smoothed and scaled screen positions.
// ----------------------------------------------------------------------------
// Bytes are taken one per cycle; the front end parses the X and Y fields as
// they arrive and hands each complete packet with in-range fields to a
// two-entry queue. The back end works a packet axis by axis, and blending is
// skipped when the previous packet was a release: each calibration and
// each blend is a signed division on one shared radix-2 divider of 42
// steps after operand setup, and the scaling to screen size is a multiply
// followed by a shift-add reciprocal step on each axis; the back end also
// pops the queue before and posts the result after this work. A result that
// waits on the output holds the back end. The byte input stalls only when
// the last byte of a packet arrives with the queue full. A result is shown
// only when position or touch state changed.
module touch_packet_decoder_core (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [7:0]   req_tdata,   // [7:0] rx_byte
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [31:0]  rsp_tdata,   // [12:0] pos_x, [25:13] pos_y, [26] moved,
                                     // [27] touch_changed, [28] touched
   input  logic         csr_we,
   input  logic [2:0]   csr_index,
   input  logic [12:0]  csr_wdata
);
   import tpd_pkg::*;

   cfg_type    cfg_ff, cfg_in;
   logic       q_push, q_full, q_pop, q_valid;
   qitem_type  q_in_item, q_out_item;

   // configuration writes
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         case (csr_index)
            REG_CAL_X_LOW:     cfg_in.cal_x_low     = csr_wdata[9:0];
            REG_CAL_Y_LOW:     cfg_in.cal_y_low     = csr_wdata[9:0];
            REG_CAL_X_HIGH:    cfg_in.cal_x_high    = csr_wdata[9:0];
            REG_CAL_Y_HIGH:    cfg_in.cal_y_high    = csr_wdata[9:0];
            REG_DISP_WIDTH:    cfg_in.disp_width    = csr_wdata;
            REG_DISP_HEIGHT:   cfg_in.disp_height   = csr_wdata;
            REG_SMOOTH_WEIGHT: cfg_in.smooth_weight = csr_wdata[7:0];
            default:           cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '{cal_x_low: 10'd128, cal_y_low: 10'd128,
                     cal_x_high: 10'd896, cal_y_high: 10'd896,
                     disp_width: 13'd1024, disp_height: 13'd768,
                     smooth_weight: 8'd0};
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   tpd_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .q_full     (q_full),
      .q_push     (q_push),
      .q_item     (q_in_item)
   );

   tpd_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_item (q_in_item),
      .full      (q_full),
      .pop       (q_pop),
      .not_empty (q_valid),
      .pop_item  (q_out_item)
   );

   tpd_back u_back (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg_ff),
      .q_valid    (q_valid),
      .q_item     (q_out_item),
      .q_pop      (q_pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   // queue is never pushed while full
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      q_push |-> !q_full) else $error("packet queue overflow");

   // queue is never popped while empty
   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      q_pop |-> q_valid) else $error("packet queue underflow");

   // every shown result reports a change
   a_result_changed: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tdata[26] || rsp_tdata[27])) else $error("result without change");

   // positions stay inside the screen
   a_clamped: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tdata[12:0] <= cfg_ff.disp_width) &&
                     (rsp_tdata[25:13] <= cfg_ff.disp_height))
      else $error("position outside screen");

endmodule
